>>> rtl/ufmst_pkg.sv
// ----------------------------------------------------------------------------
// ufmst_pkg
// shared beat types, field widths and codes for the kruskal edge filter
// ----------------------------------------------------------------------------
package ufmst_pkg;

    localparam int NODE_FIELD_W   = 10;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int TAG_W          = 16;
    localparam int COST_W         = 26;
    localparam int RANK_W         = 4;
    localparam int NODE_CNT_W     = 11;

    localparam logic [RANK_W-1:0]     RANK_MAX       = 4'd15;
    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 11'd1024;

    // command codes
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_EDGE  = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [NODE_FIELD_W-1:0]   node_a;
        logic [NODE_FIELD_W-1:0]   node_b;
        logic [WEIGHT_FIELD_W-1:0] edge_weight;
        logic [TAG_W-1:0]          edge_tag;
    } t_in_beat;

    typedef struct packed {
        logic              accepted;
        logic [COST_W-1:0] tree_cost;
        logic [TAG_W-1:0]  tag_out;
    } t_out_beat;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

endpackage

>>> rtl/ufmst_ram.sv
// ----------------------------------------------------------------------------
// ufmst_ram
// disjoint-set table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ufmst_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 14,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/ufmst_engine.sv
// ----------------------------------------------------------------------------
// ufmst_engine
// sequencer: clearing sweep, index wrap, two finds with path compression,
// union by rank and cost accumulation over the table memory
// ----------------------------------------------------------------------------
module ufmst_engine #(
    parameter int MAX_NODES   = 1024,
    parameter int WEIGHT_BITS = 16,
    parameter int NODE_W      = 10,
    parameter int ENT_W       = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  ufmst_pkg::t_in_beat                 i_item,
    input  logic [ufmst_pkg::NODE_CNT_W-1:0]    i_node_count,
    input  logic                                i_res_ready,
    output ufmst_pkg::t_eng_stat                o_stat,
    output ufmst_pkg::t_out_beat                o_res,
    output logic [NODE_W-1:0]                   o_rd_addr,
    input  logic [ENT_W-1:0]                    i_rd_data,
    output logic                                o_wr_en,
    output logic [NODE_W-1:0]                   o_wr_addr,
    output logic [ENT_W-1:0]                    o_wr_data
);

    localparam int F      = ufmst_pkg::NODE_FIELD_W;
    localparam int WF     = ufmst_pkg::WEIGHT_FIELD_W;
    localparam int RW     = ufmst_pkg::RANK_W;
    localparam int CW     = ufmst_pkg::COST_W;
    localparam int CNT_W  = NODE_W + 1;
    localparam bit WRAP_ON = (MAX_NODES < (1 << F));

    localparam logic [WF-1:0] WMASK =
        (WEIGHT_BITS >= WF) ? {WF{1'b1}} : WF'((32'd1 << WEIGHT_BITS) - 32'd1);

    // largest shift of the table size that still fits the index field
    function automatic int wrap_shift(input int n);
        int k;
        k = 0;
        for (int i = 0; i < F; i++) begin
            if ((n << i) < (1 << F)) k = i;
        end
        return k;
    endfunction

    localparam int WRAP_SH = wrap_shift(MAX_NODES);

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WRAP  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_CP    = 4'd5;
    localparam logic [3:0] S_UNI   = 4'd6;
    localparam logic [3:0] S_UPR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_lim, n_lim;
    logic                r_clear, n_clear;
    logic [F-1:0]        r_wa, n_wa;
    logic [F-1:0]        r_wb, n_wb;
    logic [3:0]          r_wk, n_wk;
    logic                r_side, n_side;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic [NODE_W-1:0]   r_root, n_root;
    logic [NODE_W-1:0]   r_ra, n_ra;
    logic [NODE_W-1:0]   r_rb, n_rb;
    logic [RW-1:0]       r_ka, n_ka;
    logic [RW-1:0]       r_kb, n_kb;
    logic [WF-1:0]       r_weight, n_weight;
    logic [ufmst_pkg::TAG_W-1:0] r_tag, n_tag;
    logic                r_acc, n_acc;
    logic [CW-1:0]       r_cost, n_cost;

    logic [NODE_W-1:0]   d_par;
    logic [RW-1:0]       d_rank;
    logic [NODE_W-1:0]   node_a, node_b, cur_start;
    logic [F:0]          w_div;
    logic [F-1:0]        wa_red, wb_red;
    logic [CW:0]         cost_sum;

    assign d_par     = i_rd_data[NODE_W-1:0];
    assign d_rank    = i_rd_data[ENT_W-1 -: RW];
    assign node_a    = NODE_W'(r_wa);
    assign node_b    = NODE_W'(r_wb);
    assign cur_start = r_side ? node_b : node_a;

    // one conditional subtract of the shifted table size per cycle
    assign w_div  = (F+1)'(MAX_NODES) << r_wk;
    assign wa_red = ({1'b0, r_wa} >= w_div) ? (r_wa - w_div[F-1:0]) : r_wa;
    assign wb_red = ({1'b0, r_wb} >= w_div) ? (r_wb - w_div[F-1:0]) : r_wb;

    assign cost_sum = {1'b0, r_cost} + (CW+1)'(r_weight);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_lim    = r_lim;
        n_clear  = r_clear;
        n_wa     = r_wa;
        n_wb     = r_wb;
        n_wk     = r_wk;
        n_side   = r_side;
        n_cur    = r_cur;
        n_root   = r_root;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_ka     = r_ka;
        n_kb     = r_kb;
        n_weight = r_weight;
        n_tag    = r_tag;
        n_acc    = r_acc;
        n_cost   = r_cost;
        o_rd_addr = r_cur;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cur;
        o_wr_data = {d_rank, r_root};

        unique case (r_state)
            S_SWEEP: begin
                if (r_cnt == r_lim) begin
                    n_state = r_clear ? S_DONE : S_IDLE;
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_cnt[NODE_W-1:0];
                    o_wr_data = {RW'(0), r_cnt[NODE_W-1:0]};
                    n_cnt     = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_wa     = i_item.node_a;
                    n_wb     = i_item.node_b;
                    n_weight = i_item.edge_weight & WMASK;
                    n_tag    = i_item.edge_tag;
                    n_acc    = 1'b0;
                    n_side   = 1'b0;
                    if (i_item.command == ufmst_pkg::CMD_CLEAR) begin
                        n_cost  = '0;
                        n_cnt   = '0;
                        n_clear = 1'b1;
                        n_lim   = (32'(i_node_count) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                                 : CNT_W'(i_node_count);
                        n_state = S_SWEEP;
                    end else if (WRAP_ON) begin
                        n_wk    = 4'(WRAP_SH);
                        n_state = S_WRAP;
                    end else begin
                        n_cur   = NODE_W'(i_item.node_a);
                        n_state = S_RD;
                    end
                end
            end
            S_WRAP: begin
                n_wa = wa_red;
                n_wb = wb_red;
                n_wk = r_wk - 4'd1;
                if (r_wk == 4'd0) begin
                    n_cur   = NODE_W'(wa_red);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_rd_addr = r_cur;
                n_state   = S_WALK;
            end
            S_WALK: begin
                if (d_par == r_cur) begin
                    n_root = r_cur;
                    if (!r_side) begin
                        n_ra = r_cur;
                        n_ka = d_rank;
                    end else begin
                        n_rb = r_cur;
                        n_kb = d_rank;
                    end
                    if (cur_start == r_cur) begin
                        if (!r_side) begin
                            n_side  = 1'b1;
                            n_cur   = node_b;
                            n_state = S_RD;
                        end else begin
                            n_state = S_UNI;
                        end
                    end else begin
                        n_cur     = cur_start;
                        o_rd_addr = cur_start;
                        n_state   = S_CP;
                    end
                end else begin
                    n_cur     = d_par;
                    o_rd_addr = d_par;
                end
            end
            S_CP: begin
                // point the visited node straight at its root, keep its rank
                o_wr_en   = 1'b1;
                o_wr_addr = r_cur;
                o_wr_data = {d_rank, r_root};
                if (d_par == r_root) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_cur   = node_b;
                        n_state = S_RD;
                    end else begin
                        n_state = S_UNI;
                    end
                end else begin
                    n_cur     = d_par;
                    o_rd_addr = d_par;
                end
            end
            S_UNI: begin
                if (r_ra == r_rb) begin
                    n_state = S_DONE;
                end else begin
                    n_acc   = 1'b1;
                    n_cost  = cost_sum[CW] ? {CW{1'b1}} : cost_sum[CW-1:0];
                    o_wr_en = 1'b1;
                    if (r_ka < r_kb) begin
                        o_wr_addr = r_ra;
                        o_wr_data = {r_ka, r_rb};
                        n_state   = S_DONE;
                    end else begin
                        o_wr_addr = r_rb;
                        o_wr_data = {r_kb, r_ra};
                        n_state   = (r_ka == r_kb && r_ka != ufmst_pkg::RANK_MAX)
                                    ? S_UPR : S_DONE;
                    end
                end
            end
            S_UPR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ra;
                o_wr_data = {r_ka + RW'(1), r_ra};
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_cnt   <= '0;
            r_lim   <= CNT_W'(MAX_NODES);
            r_clear <= 1'b0;
            r_cost  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lim   <= n_lim;
            r_clear <= n_clear;
            r_cost  <= n_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa     <= n_wa;
        r_wb     <= n_wb;
        r_wk     <= n_wk;
        r_side   <= n_side;
        r_cur    <= n_cur;
        r_root   <= n_root;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_ka     <= n_ka;
        r_kb     <= n_kb;
        r_weight <= n_weight;
        r_tag    <= n_tag;
        r_acc    <= n_acc;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

    assign o_res.accepted  = r_acc;
    assign o_res.tree_cost = r_cost;
    assign o_res.tag_out   = r_tag;

endmodule

>>> rtl/union_find_mst_edge_filter.sv
// ----------------------------------------------------------------------------
// union_find_mst_edge_filter
// kruskal edge acceptance over a disjoint-set table held in one memory
// ----------------------------------------------------------------------------
// edge: an index wrap when MAX_NODES is below 1024, then a find with path
//   compression for each endpoint, then a union by rank, with a second write
//   when a rank tie raises a rank
// one item in flight; the next input beat is taken in the cycle after the
//   result moves into the output register
// clear: min(node_count, MAX_NODES) entries, one entry written per cycle
// reset: synchronous, then a clearing pass of MAX_NODES entries, input not ready
// ----------------------------------------------------------------------------
module union_find_mst_edge_filter #(
    parameter int MAX_NODES   = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ufmst_pkg::t_in_beat              i_in_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ufmst_pkg::t_out_beat             o_out_data,
    // node count register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ufmst_pkg::NODE_CNT_W-1:0] i_cfg_data
);

    // table entry: rank above parent pointer
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int ENT_W  = ufmst_pkg::RANK_W + NODE_W;

    logic [ufmst_pkg::NODE_CNT_W-1:0] r_node_count;
    logic                             r_out_valid;
    ufmst_pkg::t_out_beat             r_out_data;

    ufmst_pkg::t_eng_stat eng_stat;
    ufmst_pkg::t_out_beat eng_res;
    logic                 start;
    logic                 res_ready;
    logic [NODE_W-1:0]    rd_addr;
    logic [ENT_W-1:0]     rd_data;
    logic                 wr_en;
    logic [NODE_W-1:0]    wr_addr;
    logic [ENT_W-1:0]     wr_data;

    // a new beat is taken whenever the sequencer is idle, even while the
    // previous result still sits in the output register
    assign start      = i_in_valid & eng_stat.idle;
    assign o_in_ready = eng_stat.idle;

    // the output register frees up in the same cycle it is read out
    assign res_ready = ~r_out_valid | i_out_ready;

    // node count register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ufmst_pkg::NODE_CNT_RESET;
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    // result register between sequencer and output channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_stat.res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_stat.res_valid && res_ready) begin
            r_out_data <= eng_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // parent/rank table
    ufmst_ram #(
        .DEPTH  (MAX_NODES),
        .WIDTH  (ENT_W),
        .ADDR_W (NODE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // find / compress / union sequencer
    ufmst_engine #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .NODE_W      (NODE_W),
        .ENT_W       (ENT_W)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_in_data),
        .i_node_count (r_node_count),
        .i_res_ready  (res_ready),
        .o_stat       (eng_stat),
        .o_res        (eng_res),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

endmodule

>>> rtl/ufmst_checker.sv
// ----------------------------------------------------------------------------
// ufmst_checker
// port-level checks on the edge filter, bound to the top level
// ----------------------------------------------------------------------------
module ufmst_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input ufmst_pkg::t_in_beat              i_in_data,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input ufmst_pkg::t_out_beat             o_out_data,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [ufmst_pkg::NODE_CNT_W-1:0] i_cfg_data
);

    logic [ufmst_pkg::COST_W-1:0] r_last_cost;
    logic                         r_seen;

    // cost of the last result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            r_last_cost <= o_out_data.tree_cost;
        end
    end

    // reset starts the clearing pass, no input taken
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("input ready or result valid right after reset");

    // one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second input beat taken while one is in work");

    // an accepted edge never lowers the running cost
    a_cost_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepted && r_seen)
            |-> (o_out_data.tree_cost >= r_last_cost))
        else $error("accepted edge lowered the tree cost");

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat dropped or changed");

endmodule

bind union_find_mst_edge_filter ufmst_checker u_ufmst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

>>> tb/ufmst_edge_checker.sv
// ----------------------------------------------------------------------------
// ufmst_edge_checker
// watches the item, result and node count channels of the kruskal edge
// filter, keeps its own disjoint-set table and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ufmst_edge_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  ufmst_pkg::t_in_beat              i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  ufmst_pkg::t_out_beat             i_out_data,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [ufmst_pkg::NODE_CNT_W-1:0] i_cfg_data,
    output int                               o_pending,
    output int                               o_fail_count,
    output int                               o_accepted_cnt
);

    localparam logic [ufmst_pkg::COST_W-1:0] COST_SAT = {ufmst_pkg::COST_W{1'b1}};
    localparam int                           SHOW_MAX = 10;

    logic [ufmst_pkg::NODE_FIELD_W-1:0] set_parent [TABLE_DEPTH];
    logic [ufmst_pkg::RANK_W-1:0]       set_rank   [TABLE_DEPTH];
    logic [ufmst_pkg::COST_W-1:0]       mst_cost;
    logic [ufmst_pkg::NODE_CNT_W-1:0]   node_cnt;
    ufmst_pkg::t_out_beat               expected_results [$];
    int                                 n_fail;
    int                                 n_accepted;

    // find with full path compression
    function automatic logic [ufmst_pkg::NODE_FIELD_W-1:0] find_set_root(
        input logic [ufmst_pkg::NODE_FIELD_W-1:0] node
    );
        logic [ufmst_pkg::NODE_FIELD_W-1:0] root;
        logic [ufmst_pkg::NODE_FIELD_W-1:0] cur;
        logic [ufmst_pkg::NODE_FIELD_W-1:0] nxt;
        int                                 steps;
        root  = node;
        steps = 0;
        while (set_parent[root] != root && steps < TABLE_DEPTH) begin
            root = set_parent[root];
            steps++;
        end
        cur   = node;
        steps = 0;
        while (cur != root && steps < TABLE_DEPTH) begin
            nxt             = set_parent[cur];
            set_parent[cur] = root;
            cur             = nxt;
            steps++;
        end
        return root;
    endfunction

    // one item through the set table, returns the result it gives
    function automatic ufmst_pkg::t_out_beat kruskal_step(input ufmst_pkg::t_in_beat beat);
        ufmst_pkg::t_out_beat               res;
        logic [ufmst_pkg::NODE_FIELD_W-1:0] root_a;
        logic [ufmst_pkg::NODE_FIELD_W-1:0] root_b;
        logic [ufmst_pkg::NODE_FIELD_W-1:0] swap;
        logic [ufmst_pkg::COST_W:0]         sum;
        int                                 lim;
        int                                 idx;
        res.accepted = 1'b0;
        res.tag_out  = beat.edge_tag;
        if (beat.command == ufmst_pkg::CMD_CLEAR) begin
            lim = (int'(node_cnt) > TABLE_DEPTH) ? TABLE_DEPTH : int'(node_cnt);
            for (idx = 0; idx < lim; idx++) begin
                set_parent[idx] = ufmst_pkg::NODE_FIELD_W'(idx);
                set_rank[idx]   = '0;
            end
            mst_cost      = '0;
            res.tree_cost = '0;
            return res;
        end
        root_a = find_set_root(beat.node_a);
        root_b = find_set_root(beat.node_b);
        if (root_a != root_b) begin
            sum          = {1'b0, mst_cost} + (ufmst_pkg::COST_W+1)'(beat.edge_weight);
            mst_cost     = (sum > {1'b0, COST_SAT}) ? COST_SAT
                                                    : sum[ufmst_pkg::COST_W-1:0];
            res.accepted = 1'b1;
            if (set_rank[root_a] < set_rank[root_b]) begin
                swap   = root_a;
                root_a = root_b;
                root_b = swap;
            end
            set_parent[root_b] = root_a;
            if (set_rank[root_a] == set_rank[root_b]
                && set_rank[root_a] < ufmst_pkg::RANK_MAX) begin
                set_rank[root_a] = set_rank[root_a] + 1'b1;
            end
        end
        res.tree_cost = mst_cost;
        return res;
    endfunction

    always @(posedge i_clk) begin
        ufmst_pkg::t_out_beat want;
        int                   idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < TABLE_DEPTH; idx++) begin
                set_parent[idx] = ufmst_pkg::NODE_FIELD_W'(idx);
                set_rank[idx]   = '0;
            end
            mst_cost   = '0;
            node_cnt   = ufmst_pkg::NODE_CNT_RESET;
            n_fail     = 0;
            n_accepted = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                node_cnt = i_cfg_data;
            end
            // result side first, so a stray beat never eats a fresh expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= SHOW_MAX) begin
                        $display("unexpected result beat: acc=%0d cost=%0d tag=%h",
                                 i_out_data.accepted, i_out_data.tree_cost,
                                 i_out_data.tag_out);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.accepted !== want.accepted
                        || i_out_data.tree_cost !== want.tree_cost
                        || i_out_data.tag_out !== want.tag_out) begin
                        n_fail++;
                        if (n_fail <= SHOW_MAX) begin
                            $display("result mismatch: expected acc=%0d cost=%0d tag=%h,",
                                     want.accepted, want.tree_cost, want.tag_out,
                                     " got acc=%0d cost=%0d tag=%h",
                                     i_out_data.accepted, i_out_data.tree_cost,
                                     i_out_data.tag_out);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = kruskal_step(i_in_data);
                if (want.accepted) begin
                    n_accepted++;
                end
                expected_results.insert(expected_results.size(), want);
            end
        end
        o_pending      <= expected_results.size();
        o_fail_count   <= n_fail;
        o_accepted_cnt <= n_accepted;
    end

endmodule

>>> tb/tb_union_find_mst_edge_filter.sv
// ----------------------------------------------------------------------------
// tb_union_find_mst_edge_filter
// drives clear commands, sorted edge runs and unsorted noise into the kruskal edge filter
// under several node counts, with random gaps on both channels; a separate
// checker predicts every result beat and counts failures
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_union_find_mst_edge_filter;

    localparam int TABLE_NODES  = 1024;
    localparam int RANDOM_ITEMS = 1630;
    localparam int N_PHASES     = 10;
    localparam int DRAIN_CYCLES = 64;
    // slowest run: ~1700 beats, each as long as a full clear behind the
    // longest gap and result stall, stays well inside this limit
    localparam int CYCLE_LIMIT  = 10_000_000;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    ufmst_pkg::t_in_beat              in_beat   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    ufmst_pkg::t_out_beat             out_beat;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ufmst_pkg::NODE_CNT_W-1:0] cfg_data  = '0;

    int pending;
    int fail_count;
    int accepted_cnt;

    // bookkeeping for the summary
    int items_sent  = 0;
    int clears_sent = 0;
    int cfg_writes  = 0;
    int cycle_cnt   = 0;
    int ready_hold  = 0;

    // when set, neither side idles: back-to-back beats
    bit smooth_flow = 1'b0;

    union_find_mst_edge_filter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ufmst_edge_checker #(
        .TABLE_DEPTH (TABLE_NODES)
    ) u_mst_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_beat),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_beat),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_accepted_cnt (accepted_cnt)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle stretch length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int roll;
        if (smooth_flow) begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // result side back-pressure: ready toggles after random hold times
    always @(posedge clk) begin
        if (smooth_flow) begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            out_ready  <= !out_ready;
            ready_hold <= idle_len();
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_cnt, pending);
            $display("FAIL union_find_mst_edge_filter");
            $finish;
        end
    end

    // one item beat, with a random gap in front; valid stays high on return
    // so a following beat with no gap keeps the channel busy
    task automatic send_beat(input ufmst_pkg::t_in_beat beat);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_clear(input int unsigned tag);
        ufmst_pkg::t_in_beat beat;
        beat          = '0;
        beat.command  = ufmst_pkg::CMD_CLEAR;
        beat.node_a   = ufmst_pkg::NODE_FIELD_W'($urandom);
        beat.node_b   = ufmst_pkg::NODE_FIELD_W'($urandom);
        beat.edge_weight = ufmst_pkg::WEIGHT_FIELD_W'($urandom);
        beat.edge_tag = ufmst_pkg::TAG_W'(tag);
        clears_sent++;
        send_beat(beat);
    endtask

    task automatic send_edge(input int unsigned a, input int unsigned b,
                             input int unsigned weight, input int unsigned tag);
        ufmst_pkg::t_in_beat beat;
        beat.command     = ufmst_pkg::CMD_EDGE;
        beat.node_a      = ufmst_pkg::NODE_FIELD_W'(a);
        beat.node_b      = ufmst_pkg::NODE_FIELD_W'(b);
        beat.edge_weight = ufmst_pkg::WEIGHT_FIELD_W'(weight);
        beat.edge_tag    = ufmst_pkg::TAG_W'(tag);
        send_beat(beat);
    endtask

    // drop valid and wait until every result beat has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // node count register write, only called with no result beats outstanding
    task automatic write_node_count(input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_data  <= ufmst_pkg::NODE_CNT_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int unsigned phase_cnt [N_PHASES];
        int unsigned span_lim;
        int unsigned span;
        int unsigned base;
        int unsigned run_len;
        int unsigned weight;
        int unsigned w_step;
        int unsigned node_a;
        int unsigned node_b;
        int          phase;
        int          phase_goal;
        int          roll;

        // reset held low, then released; the block then runs its own clearing pass
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        write_node_count(ufmst_pkg::NODE_CNT_RESET);
        send_edge(0, 1, 0, 16'h0000);              // rank tie, root of a wins
        send_edge(1, 0, 1, 16'h0001);              // same set, rejected
        send_edge(7, 7, 9, 16'h0007);              // self loop
        send_edge(2, 1, 100, 16'h0102);            // lower rank on a side, swap
        send_edge(1023, 1022, 65535, 16'hFFFF);    // top nodes, top weight
        send_edge(1022, 0, 65535, 16'h8000);       // tie between two rank-1 roots
        send_edge(10'h2AA, 10'h155, 16'hAAAA, 16'h5555);
        send_edge(10'h155, 10'h2AA, 16'hAAAA, 16'hAAAA);
        send_clear(16'hA5A5);                      // clear still gives a beat
        send_edge(0, 1, 5, 16'h1234);

        // node count zero: clear only resets the cost, the 0-1 join stays
        wait_drained();
        write_node_count(0);
        send_clear(16'h5A5A);
        send_edge(0, 1, 3, 16'h0F0F);
        send_edge(3, 4, 4, 16'hF0F0);

        // two nodes: endpoints past the count keep their old entries
        wait_drained();
        write_node_count(2);
        send_clear(16'h0000);
        send_edge(0, 1, 6, 16'h3C3C);
        send_edge(4, 3, 7, 16'hC3C3);
        send_edge(2, 5, 8, 16'h6969);

        // count above the table size clears the whole table
        wait_drained();
        write_node_count(2047);
        send_clear(16'hFFFF);
        send_edge(1023, 0, 65535, 16'h9696);

        // ---------------- random part ----------------
        phase_cnt[0] = 1024;
        phase_cnt[1] = 1;
        phase_cnt[2] = 16;
        phase_cnt[3] = 64;
        phase_cnt[4] = 2047;
        phase_cnt[5] = 0;
        phase_cnt[6] = $urandom_range(2, 1023);
        phase_cnt[7] = 300;
        phase_cnt[8] = $urandom_range(1025, 2046);
        phase_cnt[9] = 5;

        for (phase = 0; phase < N_PHASES; phase++) begin
            smooth_flow = 1'b0;
            wait_drained();
            write_node_count(phase_cnt[phase]);
            // range of node indices that a clear makes fresh in this phase, or the whole table for count zero
            span_lim = (phase_cnt[phase] == 0 || phase_cnt[phase] > TABLE_NODES)
                       ? TABLE_NODES : phase_cnt[phase];
            phase_goal = items_sent + RANDOM_ITEMS / N_PHASES;
            while (items_sent < phase_goal) begin
                smooth_flow = ($urandom_range(4) == 0);
                roll = $urandom_range(99);
                if (roll < 85) begin
                    // well-formed run: clear, then ascending edges in a window
                    send_clear($urandom);
                    case ($urandom_range(2))
                        0: begin
                            span = $urandom_range(2, 8);
                        end
                        1: begin
                            span = $urandom_range(8, 64);
                        end
                        default: begin
                            span = span_lim;
                        end
                    endcase
                    if (span > span_lim) begin
                        span = span_lim;
                    end
                    base    = $urandom_range(span_lim - span);
                    run_len = $urandom_range(1, (2 * span < 60) ? 2 * span : 60);
                    // keep the phase close to its share of items
                    if (items_sent + run_len > phase_goal) begin
                        run_len = (phase_goal > items_sent) ? phase_goal - items_sent : 1;
                    end
                    weight  = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(1000);
                    w_step  = ($urandom_range(3) == 0) ? 4000 : 40;
                    repeat (run_len) begin
                        // a few endpoints land anywhere in the table
                        node_a = ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                          : base + $urandom_range(span - 1);
                        node_b = ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                          : base + $urandom_range(span - 1);
                        send_edge(node_a, node_b, weight, $urandom);
                        weight = weight + $urandom_range(w_step);
                        if (weight > 65535) begin
                            weight = 65535;
                        end
                    end
                end else if (roll < 95) begin
                    // noise: unsorted edges anywhere, no clear in front
                    repeat ($urandom_range(1, 10)) begin
                        send_edge($urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(65535), $urandom);
                    end
                end else begin
                    send_clear($urandom);
                end
            end
        end

        // ---------------- drain and verdict ----------------
        smooth_flow = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d item beats (%0d clears), %0d edges taken into the tree",
                 items_sent, clears_sent, accepted_cnt);
        $display("node count written %0d times, zero, one and above-table among them",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("PASS union_find_mst_edge_filter");
        end else begin
            $display("%0d failing result beats", fail_count);
            $display("FAIL union_find_mst_edge_filter");
        end
        $finish;
    end

endmodule
